/* sv/bfa_pkg.sv */
// Shared types and constants of the best-fit heap allocator.
package bfa_pkg;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NOHEAP  = 2'd1,
		ST_FULL    = 2'd2,
		ST_UNKNOWN = 2'd3
	} status_t;

	// Mode codes of a request.
	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_FREE  = 1'b1;

	// Configuration register map: paddr[2] selects the register word.
	localparam int  PADDR_W        = 3;
	localparam logic REG_HEAP_LIMIT = 1'b0;
	localparam int  LIMIT_W        = 17;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 17'h10000;

	// Datapath operations issued by the controller, one per cycle.
	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_SCAN_RD,
		OP_SCAN_CMP,
		OP_OPEN_INIT,
		OP_SHIFT_RD,
		OP_OPEN_WR,
		OP_SPLIT_WR1,
		OP_SPLIT_WR2,
		OP_TAKE_WR,
		OP_APPEND_WR,
		OP_ERR,
		OP_FREE_SETUP,
		OP_LEFT_RD,
		OP_LEFT_CHK,
		OP_CLOSE_INIT,
		OP_CLOSE_WR,
		OP_CLOSE_END,
		OP_RIGHT_RD,
		OP_RIGHT_CHK,
		OP_DROP,
		OP_FREE_WR
	} op_t;

	typedef struct packed {
		op_t     op;
		status_t code;
	} cmd_t;

	typedef struct packed {
		logic mode;
		logic found;
		logic scan_done;
		logic split_ok;
		logic fits_heap;
		logic table_full;
		logic open_done;
		logic close_done;
		logic has_left;
		logic has_right;
		logic is_last;
		logic nb_free;
		logic slot_free;
		logic count_ok;
	} sts_t;

endpackage

/* sv/bfa_req_if.sv */
// Request channel: one allocate or free request.
interface bfa_req_if;
	logic        valid;
	logic        ready;
	logic        mode;
	logic [15:0] request_size;
	logic [15:0] free_address;

	modport source (output valid, mode, request_size, free_address, input ready);
	modport sink (input valid, mode, request_size, free_address, output ready);
endinterface

/* sv/bfa_rsp_if.sv */
// Result channel: address and status of one request.
interface bfa_rsp_if;
	logic        valid;
	logic        ready;
	logic [15:0] address;
	logic [1:0]  status;

	modport source (output valid, address, status, input ready);
	modport sink (input valid, address, status, output ready);
endinterface

/* sv/bfa_datapath.sv */
// Segment table memory, scan registers, heap top and result register.
module bfa_datapath #(
	parameter int MAX_SEGMENTS = 64,
	parameter int HEADER_BYTES = 24,
	parameter int ADDR_BITS    = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  bfa_pkg::cmd_t           cmd,
	output bfa_pkg::sts_t           sts,
	input  logic                    mode,
	input  logic [15:0]             request_size,
	input  logic [15:0]             free_address,
	input  logic [bfa_pkg::LIMIT_W-1:0] heap_limit,
	input  logic                    out_ready,
	output logic                    out_valid,
	output logic [15:0]             out_address,
	output logic [1:0]              out_status
);
	import bfa_pkg::*;

	localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
	localparam int CW = $clog2(MAX_SEGMENTS + 1);
	localparam int JW = CW + 1;
	localparam int SW = ADDR_BITS + 1;
	localparam int NW = 17;
	localparam int VW = ((SW > NW) ? SW : NW) + 1;
	localparam logic [VW-1:0] CAP = VW'(1) << ADDR_BITS;
	localparam logic [VW-1:0] HDR = VW'(HEADER_BYTES);

	logic [SW-1:0] mem_start [MAX_SEGMENTS];
	logic [SW-1:0] mem_size  [MAX_SEGMENTS];
	logic          mem_used  [MAX_SEGMENTS];

	logic [SW-1:0] rd_start_q, rd_size_q;
	logic          rd_used_q;

	logic          mode_q;
	logic [NW-1:0] need_q;
	logic [15:0]   faddr_q;
	logic [JW-1:0] j_q;
	logic          found_q;
	logic [IW-1:0] best_idx_q, cur_idx_q;
	logic [SW-1:0] best_start_q, best_size_q, cur_start_q, cur_size_q;
	logic [CW-1:0] count_q;
	logic [SW-1:0] heap_top_q;
	logic          valid_q;
	logic [15:0]   addr_q;
	logic [1:0]    status_q;

	logic          re, we, wused;
	logic [IW-1:0] raddr, waddr;
	logic [SW-1:0] wstart, wsize;
	logic [VW-1:0] need_v, eff_limit, rem_v, rd_size_v;
	logic          alloc_hit, free_hit, res_en;
	logic [15:0]   res_addr;

	assign need_v    = VW'(need_q);
	assign rd_size_v = VW'(rd_size_q);
	assign eff_limit = (VW'(heap_limit) > CAP) ? CAP : VW'(heap_limit);
	assign rem_v     = VW'(best_size_q) - need_v;

	assign alloc_hit = !rd_used_q && (rd_size_v >= need_v) &&
		(!found_q || rd_size_v < VW'(best_size_q));
	assign free_hit  = rd_used_q && !found_q &&
		(VW'(rd_start_q) + HDR == VW'(faddr_q));

	always_comb begin
		sts.mode       = mode_q;
		sts.found      = found_q;
		sts.scan_done  = (j_q == JW'(count_q));
		sts.split_ok   = (rem_v != '0) && (rem_v >= HDR) && (count_q < CW'(MAX_SEGMENTS));
		sts.fits_heap  = (VW'(heap_top_q) + need_v) <= eff_limit;
		sts.table_full = (count_q >= CW'(MAX_SEGMENTS));
		sts.open_done  = (j_q == JW'(best_idx_q));
		sts.close_done = (j_q >= JW'(count_q));
		sts.has_left   = (best_idx_q != '0);
		sts.has_right  = (JW'(cur_idx_q) + JW'(1)) < JW'(count_q);
		sts.is_last    = (JW'(cur_idx_q) + JW'(1)) == JW'(count_q);
		sts.nb_free    = !rd_used_q;
		sts.slot_free  = !valid_q || out_ready;
		sts.count_ok   = (count_q <= CW'(MAX_SEGMENTS));
	end

	// Memory port control decoded from the current operation.
	always_comb begin
		re       = 1'b0;
		raddr    = j_q[IW-1:0];
		we       = 1'b0;
		waddr    = best_idx_q;
		wstart   = best_start_q;
		wsize    = best_size_q;
		wused    = 1'b1;
		res_en   = 1'b0;
		res_addr = '0;
		unique case (cmd.op)
			OP_SCAN_RD, OP_SHIFT_RD: re = 1'b1;
			OP_LEFT_RD: begin
				re    = 1'b1;
				raddr = best_idx_q - IW'(1);
			end
			OP_RIGHT_RD: begin
				re    = 1'b1;
				raddr = cur_idx_q + IW'(1);
			end
			OP_OPEN_WR: begin
				we     = 1'b1;
				waddr  = IW'(j_q + JW'(1));
				wstart = rd_start_q;
				wsize  = rd_size_q;
				wused  = rd_used_q;
			end
			OP_CLOSE_WR: begin
				we     = 1'b1;
				waddr  = IW'(j_q - JW'(1));
				wstart = rd_start_q;
				wsize  = rd_size_q;
				wused  = rd_used_q;
			end
			OP_SPLIT_WR1: begin
				we     = 1'b1;
				waddr  = best_idx_q + IW'(1);
				wstart = SW'(VW'(best_start_q) + need_v);
				wsize  = SW'(rem_v);
				wused  = 1'b0;
			end
			OP_SPLIT_WR2: begin
				we       = 1'b1;
				wsize    = SW'(need_q);
				res_en   = 1'b1;
				res_addr = 16'(VW'(best_start_q) + HDR);
			end
			OP_TAKE_WR: begin
				we       = 1'b1;
				res_en   = 1'b1;
				res_addr = 16'(VW'(best_start_q) + HDR);
			end
			OP_APPEND_WR: begin
				we       = 1'b1;
				waddr    = count_q[IW-1:0];
				wstart   = heap_top_q;
				wsize    = SW'(need_q);
				res_en   = 1'b1;
				res_addr = 16'(VW'(heap_top_q) + HDR);
			end
			OP_FREE_WR: begin
				we     = 1'b1;
				waddr  = cur_idx_q;
				wstart = cur_start_q;
				wsize  = cur_size_q;
				wused  = 1'b0;
				res_en = 1'b1;
			end
			OP_ERR, OP_DROP: res_en = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem_start[waddr] <= wstart;
			mem_size[waddr]  <= wsize;
			mem_used[waddr]  <= wused;
		end
		if (re) begin
			rd_start_q <= mem_start[raddr];
			rd_size_q  <= mem_size[raddr];
			rd_used_q  <= mem_used[raddr];
		end
	end

	// Payload registers of the request in work.
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: begin
				mode_q  <= mode;
				need_q  <= NW'(request_size) + NW'(HEADER_BYTES);
				faddr_q <= free_address;
			end
			OP_SCAN_CMP: begin
				if ((mode_q == MODE_ALLOC) ? alloc_hit : free_hit) begin
					best_idx_q   <= j_q[IW-1:0];
					best_start_q <= rd_start_q;
					best_size_q  <= rd_size_q;
				end
			end
			OP_FREE_SETUP: begin
				cur_idx_q   <= best_idx_q;
				cur_start_q <= best_start_q;
				cur_size_q  <= best_size_q;
			end
			OP_LEFT_CHK: begin
				if (!rd_used_q) begin
					cur_idx_q   <= best_idx_q - IW'(1);
					cur_start_q <= rd_start_q;
					cur_size_q  <= rd_size_q + cur_size_q;
				end
			end
			OP_RIGHT_CHK: begin
				if (!rd_used_q) begin
					cur_size_q <= cur_size_q + rd_size_q;
				end
			end
			default: ;
		endcase
		if (res_en) begin
			addr_q   <= res_addr;
			status_q <= cmd.code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			j_q        <= '0;
			found_q    <= 1'b0;
			count_q    <= '0;
			heap_top_q <= '0;
			valid_q    <= 1'b0;
		end else begin
			unique case (cmd.op)
				OP_LOAD: begin
					j_q     <= '0;
					found_q <= 1'b0;
				end
				OP_SCAN_CMP: begin
					j_q <= j_q + JW'(1);
					if ((mode_q == MODE_ALLOC) ? alloc_hit : free_hit) begin
						found_q <= 1'b1;
					end
				end
				OP_OPEN_INIT: j_q <= JW'(count_q) - JW'(1);
				OP_OPEN_WR:   j_q <= j_q - JW'(1);
				OP_CLOSE_INIT: j_q <= JW'(cur_idx_q) + JW'(2);
				OP_CLOSE_WR:  j_q <= j_q + JW'(1);
				OP_CLOSE_END: count_q <= count_q - CW'(1);
				OP_SPLIT_WR2: count_q <= count_q + CW'(1);
				OP_APPEND_WR: begin
					count_q    <= count_q + CW'(1);
					heap_top_q <= SW'(VW'(heap_top_q) + need_v);
				end
				OP_DROP: begin
					count_q    <= count_q - CW'(1);
					heap_top_q <= cur_start_q;
				end
				default: ;
			endcase
			if (res_en) begin
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign out_valid   = valid_q;
	assign out_address = addr_q;
	assign out_status  = status_q;
endmodule

/* sv/bfa_controller.sv */
// Sequencer that steps the datapath through scan, shift and update phases.
module bfa_controller (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  bfa_pkg::sts_t sts,
	output bfa_pkg::cmd_t cmd
);
	import bfa_pkg::*;

	typedef enum logic [19:0] {
		S_IDLE       = 20'h00001,
		S_SCAN_RD    = 20'h00002,
		S_SCAN_CMP   = 20'h00004,
		S_DECIDE     = 20'h00008,
		S_OPEN_RD    = 20'h00010,
		S_OPEN_WR    = 20'h00020,
		S_SPLIT1     = 20'h00040,
		S_SPLIT2     = 20'h00080,
		S_TAKE       = 20'h00100,
		S_APPEND     = 20'h00200,
		S_ERR        = 20'h00400,
		S_LEFT_RD    = 20'h00800,
		S_LEFT_CHK   = 20'h01000,
		S_CLOSE_INIT = 20'h02000,
		S_CLOSE_RD   = 20'h04000,
		S_CLOSE_WR   = 20'h08000,
		S_CLOSE_END  = 20'h10000,
		S_RIGHT_RD   = 20'h20000,
		S_RIGHT_CHK  = 20'h40000,
		S_FINISH     = 20'h80000
	} state_t;

	state_t state_q, state_d;
	logic   right_q, right_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d  = state_q;
		right_d  = right_q;
		cmd.op   = OP_NONE;
		cmd.code = ST_OK;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op  = OP_LOAD;
					state_d = S_SCAN_RD;
				end
			end
			S_SCAN_RD: begin
				if (sts.scan_done) begin
					state_d = S_DECIDE;
				end else begin
					cmd.op  = OP_SCAN_RD;
					state_d = S_SCAN_CMP;
				end
			end
			S_SCAN_CMP: begin
				cmd.op  = OP_SCAN_CMP;
				state_d = S_SCAN_RD;
			end
			S_DECIDE: begin
				if (sts.mode == MODE_FREE) begin
					if (!sts.found) begin
						state_d = S_ERR;
					end else begin
						cmd.op  = OP_FREE_SETUP;
						state_d = sts.has_left ? S_LEFT_RD : S_RIGHT_RD;
					end
				end else if (sts.found) begin
					if (sts.split_ok) begin
						cmd.op  = OP_OPEN_INIT;
						state_d = S_OPEN_RD;
					end else begin
						state_d = S_TAKE;
					end
				end else if (!sts.fits_heap || sts.table_full) begin
					state_d = S_ERR;
				end else begin
					state_d = S_APPEND;
				end
			end
			S_OPEN_RD: begin
				if (sts.open_done) begin
					state_d = S_SPLIT1;
				end else begin
					cmd.op  = OP_SHIFT_RD;
					state_d = S_OPEN_WR;
				end
			end
			S_OPEN_WR: begin
				cmd.op  = OP_OPEN_WR;
				state_d = S_OPEN_RD;
			end
			S_SPLIT1: begin
				cmd.op  = OP_SPLIT_WR1;
				state_d = S_SPLIT2;
			end
			S_SPLIT2: begin
				if (sts.slot_free) begin
					cmd.op  = OP_SPLIT_WR2;
					state_d = S_IDLE;
				end
			end
			S_TAKE: begin
				if (sts.slot_free) begin
					cmd.op  = OP_TAKE_WR;
					state_d = S_IDLE;
				end
			end
			S_APPEND: begin
				if (sts.slot_free) begin
					cmd.op  = OP_APPEND_WR;
					state_d = S_IDLE;
				end
			end
			S_ERR: begin
				if (sts.slot_free) begin
					cmd.op = OP_ERR;
					priority if (sts.mode == MODE_FREE) cmd.code = ST_UNKNOWN;
					else if (!sts.fits_heap) cmd.code = ST_NOHEAP;
					else cmd.code = ST_FULL;
					state_d = S_IDLE;
				end
			end
			S_LEFT_RD: begin
				cmd.op  = OP_LEFT_RD;
				state_d = S_LEFT_CHK;
			end
			S_LEFT_CHK: begin
				cmd.op = OP_LEFT_CHK;
				if (sts.nb_free) begin
					right_d = 1'b0;
					state_d = S_CLOSE_INIT;
				end else begin
					state_d = S_RIGHT_RD;
				end
			end
			S_CLOSE_INIT: begin
				cmd.op  = OP_CLOSE_INIT;
				state_d = S_CLOSE_RD;
			end
			S_CLOSE_RD: begin
				if (sts.close_done) begin
					state_d = S_CLOSE_END;
				end else begin
					cmd.op  = OP_SHIFT_RD;
					state_d = S_CLOSE_WR;
				end
			end
			S_CLOSE_WR: begin
				cmd.op  = OP_CLOSE_WR;
				state_d = S_CLOSE_RD;
			end
			S_CLOSE_END: begin
				cmd.op  = OP_CLOSE_END;
				state_d = right_q ? S_FINISH : S_RIGHT_RD;
			end
			S_RIGHT_RD: begin
				if (sts.has_right) begin
					cmd.op  = OP_RIGHT_RD;
					state_d = S_RIGHT_CHK;
				end else begin
					state_d = S_FINISH;
				end
			end
			S_RIGHT_CHK: begin
				cmd.op = OP_RIGHT_CHK;
				if (sts.nb_free) begin
					right_d = 1'b1;
					state_d = S_CLOSE_INIT;
				end else begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				// The last segment is dropped instead of written back free.
				if (sts.slot_free) begin
					cmd.op  = sts.is_last ? OP_DROP : OP_FREE_WR;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			right_q <= 1'b0;
		end else begin
			state_q <= state_d;
			right_q <= right_d;
		end
	end
endmodule

/* sv/best_fit_heap_allocator.sv */
// Best-fit heap allocator: a request first scans the table, where each entry
// is read from the segment table and compared in the next cycle. Then each
// entry is moved by a read and a write when a split opens a slot or a merge
// closes one, and the setup and update steps follow. The slowest request is a
// free that merges with both neighbors near the table start. A new request is
// taken while the previous result still waits on the result channel.
module best_fit_heap_allocator #(
	parameter int MAX_SEGMENTS = 64,
	parameter int HEADER_BYTES = 24,
	parameter int ADDR_BITS    = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	bfa_req_if.sink                      req,
	bfa_rsp_if.source                    rsp,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [bfa_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);
	import bfa_pkg::*;

	logic [LIMIT_W-1:0] heap_limit_q;
	cmd_t               cmd;
	sts_t               sts;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_HEAP_LIMIT) ? 32'(heap_limit_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_limit_q <= LIMIT_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_HEAP_LIMIT) begin
			heap_limit_q <= pwdata[LIMIT_W-1:0];
		end
	end

	bfa_controller u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	bfa_datapath #(
		.MAX_SEGMENTS (MAX_SEGMENTS),
		.HEADER_BYTES (HEADER_BYTES),
		.ADDR_BITS    (ADDR_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.mode         (req.mode),
		.request_size (req.request_size),
		.free_address (req.free_address),
		.heap_limit   (heap_limit_q),
		.out_ready    (rsp.ready),
		.out_valid    (rsp.valid),
		.out_address  (rsp.address),
		.out_status   (rsp.status)
	);

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n) sts.count_ok)
		else $error("segment count above table depth");
	a_accept_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |-> cmd.op == OP_LOAD)
		else $error("request accepted without load");
	a_append_legal: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_APPEND_WR |-> (sts.fits_heap && !sts.table_full))
		else $error("append issued without room");
	a_result_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.ready) |=> rsp.valid)
		else $error("pending result lost");
`endif
endmodule

/* tb/sv/bfa_checker.sv */
// Checker of the best-fit heap allocator: tracks the segment table and compares results.
module bfa_checker
	import bfa_pkg::*;
#(
	parameter int MAX_SEGMENTS = 64,
	parameter int HEADER_BYTES = 24,
	parameter int ADDR_BITS    = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	bfa_req_if                   req,
	bfa_rsp_if                   rsp,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic                 pready,
	input  logic [PADDR_W-1:0]   paddr,
	input  logic [31:0]          pwdata,
	output int                   fails,
	output int                   pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [15:0] address;
		status_t     status;
	} alloc_result_t;

	logic [LIMIT_W-1:0] heap_limit;
	logic [16:0]        seg_start [MAX_SEGMENTS];
	logic [16:0]        seg_size  [MAX_SEGMENTS];
	logic               seg_used  [MAX_SEGMENTS];
	int                 seg_count;
	int                 heap_top;
	alloc_result_t      awaited[$];

	assign pending = awaited.size();

	function automatic int usable_limit();
		int cap;
		cap = 1 << ADDR_BITS;
		return (int'(heap_limit) > cap) ? cap : int'(heap_limit);
	endfunction

	function automatic void remove_entry(input int pos);
		for (int i = pos; i + 1 < seg_count; i++) begin
			seg_start[i] = seg_start[i+1];
			seg_size[i]  = seg_size[i+1];
			seg_used[i]  = seg_used[i+1];
		end
		seg_count--;
	endfunction

	function automatic alloc_result_t allocate(input int payload);
		alloc_result_t r;
		int need;
		int best;
		int rem;
		r = '{16'd0, ST_OK};
		need = payload + HEADER_BYTES;
		best = -1;
		for (int i = 0; i < seg_count; i++) begin
			if (!seg_used[i] && int'(seg_size[i]) >= need &&
					(best < 0 || seg_size[i] < seg_size[best]))
				best = i;
		end
		if (best >= 0) begin
			rem = int'(seg_size[best]) - need;
			// Split only when the leftover can hold its own header and a slot is free.
			if (rem > 0 && rem >= HEADER_BYTES && seg_count < MAX_SEGMENTS) begin
				for (int j = seg_count; j > best + 1; j--) begin
					seg_start[j] = seg_start[j-1];
					seg_size[j]  = seg_size[j-1];
					seg_used[j]  = seg_used[j-1];
				end
				seg_start[best+1] = seg_start[best] + 17'(need);
				seg_size[best+1]  = 17'(rem);
				seg_used[best+1]  = 1'b0;
				seg_size[best]    = 17'(need);
				seg_count++;
			end
			seg_used[best] = 1'b1;
			r.address = 16'(seg_start[best] + 17'(HEADER_BYTES));
		end else if (heap_top + need > usable_limit()) begin
			r.status = ST_NOHEAP;
		end else if (seg_count >= MAX_SEGMENTS) begin
			r.status = ST_FULL;
		end else begin
			seg_start[seg_count] = 17'(heap_top);
			seg_size[seg_count]  = 17'(need);
			seg_used[seg_count]  = 1'b1;
			seg_count++;
			heap_top += need;
			r.address = 16'(heap_top - need + HEADER_BYTES);
		end
		return r;
	endfunction

	function automatic alloc_result_t release_block(input logic [15:0] addr);
		int k;
		k = -1;
		for (int i = 0; i < seg_count; i++) begin
			if (k < 0 && seg_used[i] && int'(seg_start[i]) + HEADER_BYTES == int'(addr))
				k = i;
		end
		if (k < 0)
			return '{16'd0, ST_UNKNOWN};
		seg_used[k] = 1'b0;
		if (k > 0 && !seg_used[k-1]) begin
			seg_size[k-1] += seg_size[k];
			remove_entry(k);
			k--;
		end
		if (k + 1 < seg_count && !seg_used[k+1]) begin
			seg_size[k] += seg_size[k+1];
			remove_entry(k + 1);
		end
		if (k + 1 == seg_count) begin
			heap_top = int'(seg_start[k]);
			seg_count--;
		end
		return '{16'd0, ST_OK};
	endfunction

	always @(posedge clk or negedge arst_n) begin
		alloc_result_t exp_r;
		if (!arst_n) begin
			heap_limit = LIMIT_RESET;
			seg_count  = 0;
			heap_top   = 0;
			for (int i = 0; i < MAX_SEGMENTS; i++) seg_used[i] = 1'b0;
			awaited.delete();
			fails = 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr[2] == REG_HEAP_LIMIT)
				heap_limit = pwdata[LIMIT_W-1:0];
			if (req.valid && req.ready) begin
				if (req.mode == MODE_ALLOC)
					awaited.push_back(allocate(int'(req.request_size)));
				else
					awaited.push_back(release_block(req.free_address));
			end
			if (rsp.valid && rsp.ready) begin
				if (awaited.size() == 0) begin
					fails++;
					if (fails <= 10)
						$display("unexpected result: address %0d status %0d",
							rsp.address, rsp.status);
				end else begin
					exp_r = awaited.pop_front();
					if (rsp.address !== exp_r.address || rsp.status !== exp_r.status) begin
						fails++;
						if (fails <= 10)
							$display("mismatch: expected address %0d status %0d, got address %0d status %0d",
								exp_r.address, exp_r.status, rsp.address, rsp.status);
					end
				end
			end
		end
	end
endmodule

/* tb/sv/tb_top.sv */
// Top of the allocator testbench: clock, reset, request and register stimulus, verdict.
module tb_top;
	import bfa_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SETTLE = 300;
	localparam int HOLD_CYCLES = 400;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;
	int                 fails;
	int                 pending;
	int                 hold_left;
	int                 stall_left;
	bit                 hold_req;
	bit                 hold_done;
	bit                 no_idle;
	logic               sent_modes[$];
	logic [15:0]        live[$];

	bfa_req_if req_ch();
	bfa_rsp_if rsp_ch();

	best_fit_heap_allocator uut (
		.clk(clk), .arst_n(arst_n), .req(req_ch), .rsp(rsp_ch),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	bfa_checker chk (
		.clk(clk), .arst_n(arst_n), .req(req_ch), .rsp(rsp_ch),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata), .fails(fails), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("Test completed with failures");
		$finish;
	end

	function automatic int gap_length();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// Result side: random stalls, plus a long hold-off on request from the stimulus.
	always @(posedge clk) begin
		if (rsp_ch.valid && rsp_ch.ready) begin
			if (sent_modes.pop_front() == MODE_ALLOC && rsp_ch.status == ST_OK)
				live.push_back(rsp_ch.address);
		end
		if (hold_req && !hold_done) begin
			hold_done <= 1'b1;
			rsp_ch.ready <= 1'b0;
			hold_left <= HOLD_CYCLES;
		end else if (hold_left > 0) begin
			rsp_ch.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (stall_left > 0) begin
			rsp_ch.ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			rsp_ch.ready <= 1'b1;
			stall_left <= gap_length();
		end
	end

	task automatic send_request(input logic m, input logic [15:0] size_v,
			input logic [15:0] addr_v);
		int g;
		req_ch.valid        <= 1'b1;
		req_ch.mode         <= m;
		req_ch.request_size <= size_v;
		req_ch.free_address <= addr_v;
		do @(posedge clk); while (!req_ch.ready);
		sent_modes.push_back(m);
		g = gap_length();
		if (g > 0) begin
			req_ch.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic do_alloc(input logic [15:0] size_v);
		send_request(MODE_ALLOC, size_v, 16'($urandom));
	endtask

	task automatic do_free(input logic [15:0] addr_v);
		for (int i = 0; i < live.size(); i++) begin
			if (live[i] == addr_v) begin
				live.delete(i);
				break;
			end
		end
		send_request(MODE_FREE, 16'($urandom), addr_v);
	endtask

	task automatic drain();
		@(posedge clk);
		req_ch.valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_limit(input int value);
		drain();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {REG_HEAP_LIMIT, 2'b00};
		pwdata  <= 32'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic random_phase(input int count, input int free_pct);
		int r;
		for (int n = 0; n < count; n++) begin
			r = $urandom_range(0, 99);
			if (live.size() > 0 && r < free_pct)
				do_free(live[$urandom_range(0, live.size() - 1)]);
			else if (r >= 95)
				do_free(16'($urandom));
			else if ($urandom_range(0, 9) == 0)
				do_alloc(16'($urandom));
			else
				do_alloc(16'($urandom_range(0, 300)));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req_ch.valid = 1'b0;
		req_ch.mode = MODE_ALLOC;
		req_ch.request_size = '0;
		req_ch.free_address = '0;
		hold_req = 1'b0;
		no_idle = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty header block, oversized request, exact fit, double free,
		// small leftover taken whole, split, and a last-segment free that merges.
		do_alloc(16'd0);
		do_alloc(16'hFFFF);
		do_alloc(16'd100);
		do_alloc(16'd200);
		do_alloc(16'd50);
		do_free(16'd48);
		do_alloc(16'd100);
		do_free(16'd48);
		do_free(16'd48);
		do_free(16'hFFFF);
		do_alloc(16'd90);
		do_free(16'd172);
		do_alloc(16'd10);
		do_free(16'd396);
		do_free(16'd48);
		do_free(16'd172);
		do_free(16'd24);
		drain();

		write_limit(65536);
		random_phase(300, 30);
		write_limit(0);
		random_phase(60, 40);
		write_limit(131071);
		no_idle = 1'b1;
		random_phase(150, 40);
		no_idle = 1'b0;
		write_limit(1500);
		random_phase(150, 45);
		write_limit(65536);
		random_phase(60, 35);
		// Hold the result side off long enough for the block to back up.
		hold_req <= 1'b1;
		random_phase(60, 35);
		drain();
		random_phase(150, 60);

		drain();
		if (fails == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end
endmodule

/* best_fit_heap_allocator.f */
sv/bfa_pkg.sv
sv/bfa_req_if.sv
sv/bfa_rsp_if.sv
sv/bfa_datapath.sv
sv/bfa_controller.sv
sv/best_fit_heap_allocator.sv
tb/sv/bfa_checker.sv
tb/sv/tb_top.sv
